// ===== hdl/ssf_pkg.sv =====
// Shared types and constants of the strided slice stream filter.
`timescale 1ns / 1ps
package ssf_pkg;

  // Number of tensor axes, in NHWC order
  localparam int AXES = 4;
  localparam int AXIS_BITS = 2;

  // Setup register layout: four 16-bit slots
  localparam int SETUP_BITS = 64;
  localparam int SLOT_BITS = 16;
  localparam int SLOT_SIZE = 0;
  localparam int SLOT_BEGIN = 16;
  localparam int SLOT_END = 32;
  localparam int SLOT_STRIDE = 48;
  localparam logic [SETUP_BITS-1:0] RESET_SETUP = 64'h0001_0001_0000_0001;

  // Configuration index port: wider than the register list so that stray
  // indexes can be recognized and dropped
  localparam int CFG_INDEX_BITS = 3;

  // Element width
  localparam int VALUE_BITS = 32;

  // Result queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = 2;

  // Register indexes of the configuration port
  typedef enum logic [AXIS_BITS-1:0] {
    REG_AXIS_N = 2'd0,
    REG_AXIS_H = 2'd1,
    REG_AXIS_W = 2'd2,
    REG_AXIS_C = 2'd3
  } ssf_reg_t;

  // One result item
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
    logic                  empty;
  } ssf_result_t;

endpackage

// ===== hdl/ssf_front.sv =====
// Front part: setup registers, coordinate counters and element classification.
`timescale 1ns / 1ps
module ssf_front #(
  parameter int DIM_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ssf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ssf_pkg::SETUP_BITS-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ssf_pkg::VALUE_BITS-1:0]   elem_value,
  input  logic                             queue_full,
  output logic                             push,
  output ssf_pkg::ssf_result_t             push_data
);
  import ssf_pkg::*;

  localparam logic [DIM_BITS-1:0] RESET_BEG = DIM_BITS'(RESET_SETUP >> SLOT_BEGIN);

  logic [SETUP_BITS-1:0] setup [AXES];
  logic [DIM_BITS-1:0]   coord [AXES];
  logic [DIM_BITS-1:0]   pick [AXES];
  logic                  any_emitted;

  logic [DIM_BITS-1:0]   coord_next [AXES];
  logic [DIM_BITS-1:0]   pick_next [AXES];
  logic [DIM_BITS-1:0]   ax_size [AXES];
  logic [DIM_BITS-1:0]   ax_beg [AXES];
  logic [DIM_BITS-1:0]   ax_end [AXES];
  logic [DIM_BITS-1:0]   ax_stride [AXES];
  logic [DIM_BITS-1:0]   new_beg;
  logic [AXES-1:0]       ax_sel;
  logic [AXES-1:0]       ax_last;
  logic [AXES-1:0]       ax_fin;
  logic                  sel;
  logic                  fin;
  logic                  take;
  logic                  cfg_hit;
  ssf_reg_t              cfg_reg;

  assign cfg_ready = 1'b1;
  assign in_ready  = !queue_full;
  assign take      = in_valid && !queue_full;
  assign cfg_reg   = ssf_reg_t'(cfg_index[AXIS_BITS-1:0]);
  assign cfg_hit   = cfg_valid && (cfg_index[CFG_INDEX_BITS-1:AXIS_BITS] == '0);
  assign new_beg   = cfg_data[SLOT_BEGIN +: DIM_BITS];

  // Decode each axis: zero size and stride become one, end clamps to size
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ax_size[a]   = setup[a][SLOT_SIZE +: DIM_BITS];
      ax_beg[a]    = setup[a][SLOT_BEGIN +: DIM_BITS];
      ax_end[a]    = setup[a][SLOT_END +: DIM_BITS];
      ax_stride[a] = setup[a][SLOT_STRIDE +: DIM_BITS];
      if (ax_size[a] == '0) begin
        ax_size[a] = DIM_BITS'(1);
      end
      if (ax_stride[a] == '0) begin
        ax_stride[a] = DIM_BITS'(1);
      end
      if (ax_end[a] > ax_size[a]) begin
        ax_end[a] = ax_size[a];
      end
    end
  end

  // Classify the current coordinate on each axis
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ax_sel[a]  = (coord[a] == pick[a]) && (coord[a] < ax_end[a]);
      ax_last[a] = ({1'b0, coord[a]} + {1'b0, ax_stride[a]}) >= {1'b0, ax_end[a]};
      ax_fin[a]  = ({1'b0, coord[a]} + (DIM_BITS+1)'(1)) >= {1'b0, ax_size[a]};
    end
  end

  assign sel = &ax_sel;
  assign fin = &ax_fin;

  // Build the result for this element
  always_comb begin
    push_data.value = elem_value;
    push_data.last  = &ax_last;
    push_data.empty = 1'b0;
    push = 1'b0;
    if (take) begin
      if (sel) begin
        push = 1'b1;
      end else if (fin && !any_emitted) begin
        push = 1'b1;
        push_data.value = '0;
        push_data.last  = 1'b0;
        push_data.empty = 1'b1;
      end
    end
  end

  // Advance the coordinate odometer, channel axis fastest
  always_comb begin
    logic                carry;
    logic [DIM_BITS:0]   step;
    carry = 1'b1;
    step  = '0;
    for (int a = 0; a < AXES; a++) begin
      coord_next[a] = coord[a];
      pick_next[a]  = pick[a];
    end
    for (int a = AXES - 1; a >= 0; a--) begin
      if (carry) begin
        if (ax_fin[a]) begin
          coord_next[a] = '0;
          pick_next[a]  = ax_beg[a];
        end else begin
          if (coord[a] == pick[a]) begin
            step = {1'b0, pick[a]} + {1'b0, ax_stride[a]};
            pick_next[a] = step[DIM_BITS] ? '1 : step[DIM_BITS-1:0];
          end
          coord_next[a] = coord[a] + DIM_BITS'(1);
          carry = 1'b0;
        end
      end
    end
  end

  // Setup writes restart the tensor; accepted elements advance it
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        setup[a] <= RESET_SETUP;
        coord[a] <= '0;
        pick[a]  <= RESET_BEG;
      end
      any_emitted <= 1'b0;
    end else if (cfg_hit) begin
      setup[cfg_reg] <= cfg_data;
      for (int a = 0; a < AXES; a++) begin
        coord[a] <= '0;
        pick[a]  <= (AXIS_BITS'(a) == cfg_reg) ? new_beg : ax_beg[a];
      end
      any_emitted <= 1'b0;
    end else if (take) begin
      for (int a = 0; a < AXES; a++) begin
        coord[a] <= coord_next[a];
        pick[a]  <= pick_next[a];
      end
      if (fin) begin
        any_emitted <= 1'b0;
      end else if (sel) begin
        any_emitted <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/ssf_queue.sv =====
// Result queue between the classifying front and the output back.
`timescale 1ns / 1ps
module ssf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ssf_pkg::ssf_result_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output ssf_pkg::ssf_result_t head_data
);
  import ssf_pkg::*;

  ssf_result_t               entry [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;
  logic                      do_push;
  logic                      do_pop;

  assign full       = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store pushed results
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QUEUE_PTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QUEUE_PTR_BITS+1)'(1);
      end
    end
  end

endmodule

// ===== hdl/ssf_back.sv =====
// Back part: output register that presents results on the output channel.
`timescale 1ns / 1ps
module ssf_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  ssf_pkg::ssf_result_t            head_data,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ssf_pkg::VALUE_BITS-1:0]  out_value,
  output logic                            out_last,
  output logic                            slice_empty
);
  import ssf_pkg::*;

  ssf_result_t held;

  // Load a new result when the register is free or being drained
  assign pop = head_valid && (!out_valid || out_ready);

  assign out_value   = held.value;
  assign out_last    = held.last;
  assign slice_empty = held.empty;

  // Hold the payload until the transaction completes
  always_ff @(posedge clk) begin
    if (pop) begin
      held <= head_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/strided_slice_stream_filter.sv =====
// Top level of the strided four-axis slice filter for NHWC element streams.
//
//   channel  signals                                   direction
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in  (setup writes)
//   in       in_valid/in_ready, elem_value             in  (one element each)
//   out      out_valid/out_ready, out_value,           out (selected elements,
//            out_last, slice_empty                          empty-slice flag)
//
// One element is accepted per cycle while the result queue has room; the front
// classifies it in the accept cycle, and its result enters the queue and then
// the output register, which loads once it is empty or being drained.
// A four-entry result queue decouples the front from the output register;
// in_ready drops only while that queue is full.
// Synchronous reset restores every axis setup (size 1, begin 0, end 1,
// stride 1) and restarts the tensor; any setup write also restarts it.
// cfg_ready is always high; indexes beyond the four axes are dropped.
`timescale 1ns / 1ps
module strided_slice_stream_filter #(
  parameter int DIM_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ssf_pkg::SETUP_BITS-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ssf_pkg::VALUE_BITS-1:0]     elem_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ssf_pkg::VALUE_BITS-1:0]     out_value,
  output logic                               out_last,
  output logic                               slice_empty
);
  import ssf_pkg::*;

  logic        push;
  ssf_result_t push_data;
  logic        queue_full;
  logic        pop;
  logic        head_valid;
  ssf_result_t head_data;

  // Classify incoming elements
  ssf_front #(
    .DIM_BITS(DIM_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .elem_value (elem_value),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // Buffer results between the two sides
  ssf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Present results
  ssf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .out_last    (out_last),
    .slice_empty (slice_empty)
  );

endmodule
